>>> rtl/bb3_pkg.sv
// Shared types and constants for the 3x3 box blur unit.
package bb3_pkg;

  localparam int CFG_W = 11;
  localparam int CH_W = 8;
  localparam int PIX_W = 3 * CH_W;
  localparam int SUM_W = 12;
  localparam int CNT_W = 4;
  localparam int RCP_W = 17;
  localparam int RCP_SHIFT = 16;

  localparam logic REG_FRAME_WIDTH = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  typedef struct packed {
    logic            cmd;
    logic [CH_W-1:0] red_in;
    logic [CH_W-1:0] green_in;
    logic [CH_W-1:0] blue_in;
  } in_word_t;

  typedef struct packed {
    logic [CH_W-1:0] red_out;
    logic [CH_W-1:0] green_out;
    logic [CH_W-1:0] blue_out;
    logic            frame_end;
  } out_word_t;

  // ceil(2^16 / count); exact floor quotient for sums below 2296
  function automatic logic [RCP_W-1:0] recip(input logic [CNT_W-1:0] count);
    logic [RCP_W-1:0] r;
    case (count)
      4'd1:    r = 17'd65536;
      4'd2:    r = 17'd32768;
      4'd3:    r = 17'd21846;
      4'd4:    r = 17'd16384;
      4'd5:    r = 17'd13108;
      4'd6:    r = 17'd10923;
      4'd7:    r = 17'd9363;
      4'd8:    r = 17'd8192;
      4'd9:    r = 17'd7282;
      default: r = 17'd65536;
    endcase
    return r;
  endfunction

endpackage

>>> rtl/box_blur_3x3_rgb_unit.sv
// 3x3 box blur over an RGB raster stream with two line stores in one RAM.
// A taken word passes the line RAM read and write-back state and, if it gives a
// result, the sum and divide states; divide loads the output register once it is
// free. The next word is taken only when the unit is idle again.
// Reset: width 640, height 480, counters, window state and output valid clear;
// line RAM contents are not cleared.
module box_blur_3x3_rgb_unit #(
  parameter int MAX_WIDTH = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  bb3_pkg::in_word_t                in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output bb3_pkg::out_word_t               out_data,
  input  logic                             cfg_we,
  input  logic                             cfg_index,
  input  logic [bb3_pkg::CFG_W-1:0]        cfg_data
);

  import bb3_pkg::*;

  localparam int XW = ($clog2(MAX_WIDTH + 1) > CFG_W) ? $clog2(MAX_WIDTH + 1) : CFG_W;
  localparam int YW = ($clog2(MAX_HEIGHT + 1) > CFG_W) ? $clog2(MAX_HEIGHT + 1) : CFG_W;
  localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_RD   = 4'b0010,
    S_SUM  = 4'b0100,
    S_DIV  = 4'b1000
  } state_t;

  state_t state, state_next;

  logic [CFG_W-1:0] frame_width, frame_height;
  logic [XW-1:0]    eff_w;
  logic [YW-1:0]    eff_h;

  logic [XW-1:0] in_col, in_col_next;
  logic [1:0]    in_row, in_row_next;
  logic [XW-1:0] out_col, out_col_next;
  logic [YW-1:0] out_row, out_row_next;

  logic [PIX_W-1:0] pix;
  logic [PIX_W-1:0] win [3][3];
  logic [8:0]       mask, mask_next;
  logic             last, last_next;
  logic             primed;

  logic [2*PIX_W-1:0] ram_rdata, ram_wdata;
  logic               ram_we;

  logic [SUM_W-1:0] sum [3];
  logic [SUM_W-1:0] sum_next [3];
  logic [CNT_W-1:0] count;
  logic [RCP_W-1:0] rcp;
  logic [SUM_W+RCP_W-1:0] prod [3];

  logic row_top, row_bot, col_lft, col_rgt;

  assign eff_w = (frame_width == '0) ? XW'(1) :
                 ({{(XW-CFG_W){1'b0}}, frame_width} > XW'(MAX_WIDTH)) ? XW'(MAX_WIDTH) :
                 {{(XW-CFG_W){1'b0}}, frame_width};
  assign eff_h = (frame_height == '0) ? YW'(1) :
                 ({{(YW-CFG_W){1'b0}}, frame_height} > YW'(MAX_HEIGHT)) ? YW'(MAX_HEIGHT) :
                 {{(YW-CFG_W){1'b0}}, frame_height};

  assign in_ready = (state == S_IDLE);

  // {upper, middle} per column
  assign ram_we = (state == S_RD);
  assign ram_wdata = {ram_rdata[PIX_W-1:0], pix};

  bb3_ram #(
    .WIDTH(2 * PIX_W),
    .DEPTH(MAX_WIDTH)
  ) u_line_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(in_col[AW-1:0]),
    .wdata(ram_wdata),
    .raddr(in_col[AW-1:0]),
    .rdata(ram_rdata)
  );

  assign primed = (in_row == 2'd2) || (in_row == 2'd1 && in_col != '0);

  always_comb begin
    row_top = (out_row != '0);
    row_bot = ((out_row + YW'(1)) < eff_h);
    col_lft = (out_col != '0);
    col_rgt = ((out_col + XW'(1)) < eff_w);
    mask_next = {row_bot & col_rgt, row_bot, row_bot & col_lft,
                 col_rgt, 1'b1, col_lft,
                 row_top & col_rgt, row_top, row_top & col_lft};
    last_next = !row_bot && !col_rgt;
  end

  always_comb begin
    in_col_next = in_col + XW'(1);
    in_row_next = in_row;
    if (in_col_next >= eff_w) begin
      in_col_next = '0;
      if (in_row != 2'd2) begin
        in_row_next = in_row + 2'd1;
      end
    end
    out_col_next = out_col;
    out_row_next = out_row;
    if (primed) begin
      out_col_next = out_col + XW'(1);
      if (out_col_next >= eff_w) begin
        out_col_next = '0;
        out_row_next = out_row + YW'(1);
      end
      if (last_next) begin
        in_col_next = '0;
        in_row_next = '0;
        out_col_next = '0;
        out_row_next = '0;
      end
    end
  end

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      sum_next[ch] = '0;
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          if (mask[r*3+c]) begin
            sum_next[ch] = sum_next[ch] + SUM_W'(win[r][c][CH_W*ch +: CH_W]);
          end
        end
      end
    end
  end

  assign rcp = recip(count);

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      prod[ch] = sum[ch] * rcp;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (in_valid) state_next = S_RD;
      S_RD:    state_next = primed ? S_SUM : S_IDLE;
      S_SUM:   state_next = S_DIV;
      S_DIV:   if (!out_valid || out_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      frame_width <= CFG_W'(640);
      frame_height <= CFG_W'(480);
      in_col <= '0;
      in_row <= '0;
      out_col <= '0;
      out_row <= '0;
      out_valid <= 1'b0;
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          win[r][c] <= '0;
        end
      end
    end else begin
      state <= state_next;
      if (cfg_we) begin
        case (cfg_index)
          REG_FRAME_WIDTH:  frame_width <= cfg_data;
          REG_FRAME_HEIGHT: frame_height <= cfg_data;
          default:          frame_width <= frame_width;
        endcase
        in_col <= '0;
        in_row <= '0;
        out_col <= '0;
        out_row <= '0;
      end else if (state == S_RD) begin
        in_col <= in_col_next;
        in_row <= in_row_next;
        out_col <= out_col_next;
        out_row <= out_row_next;
      end
      if (state == S_RD) begin
        for (int r = 0; r < 3; r++) begin
          win[r][0] <= win[r][1];
          win[r][1] <= win[r][2];
        end
        win[0][2] <= ram_rdata[2*PIX_W-1:PIX_W];
        win[1][2] <= ram_rdata[PIX_W-1:0];
        win[2][2] <= pix;
      end
      if (state == S_DIV && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      pix <= in_data.cmd ? '0 : {in_data.blue_in, in_data.green_in, in_data.red_in};
    end
    if (state == S_RD) begin
      mask <= mask_next;
      last <= last_next;
    end
    if (state == S_SUM) begin
      for (int ch = 0; ch < 3; ch++) begin
        sum[ch] <= sum_next[ch];
      end
      count <= CNT_W'($countones(mask));
    end
    if (state == S_DIV && (!out_valid || out_ready)) begin
      out_data.red_out <= prod[0][RCP_SHIFT +: CH_W];
      out_data.green_out <= prod[1][RCP_SHIFT +: CH_W];
      out_data.blue_out <= prod[2][RCP_SHIFT +: CH_W];
      out_data.frame_end <= last;
    end
  end

endmodule

>>> rtl/bb3_ram.sv
// Generic single-clock RAM, one write port, one registered read port.
module bb3_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 1024
) (
  input  logic                                        clk,
  input  logic                                        we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                            wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> tb/sv/tb.sv
// Testbench for the 3x3 RGB box blur unit: directed and random frames checked against a predictor.
module tb;
  import bb3_pkg::*;

  localparam int LINE_DEPTH = 1024;
  localparam int MAX_ROWS = 1024;
  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  class blur_scoreboard;
    bit [CFG_W-1:0] width_reg;
    bit [CFG_W-1:0] height_reg;
    bit [PIX_W-1:0] upper_row [LINE_DEPTH];
    bit [PIX_W-1:0] middle_row [LINE_DEPTH];
    bit [PIX_W-1:0] win [3][3];
    int unsigned rows_in;
    int unsigned col_in;
    int unsigned row_out;
    int unsigned col_out;
    out_word_t blurred_q [$];
    int errors;
    int checked;

    function new();
      width_reg = 11'd640;
      height_reg = 11'd480;
      foreach (win[r, c]) win[r][c] = '0;
      errors = 0;
      checked = 0;
      restart();
    endfunction

    function void restart();
      rows_in = 0;
      col_in = 0;
      row_out = 0;
      col_out = 0;
    endfunction

    function void set_reg(logic idx, bit [CFG_W-1:0] val);
      if (idx == REG_FRAME_WIDTH) begin
        width_reg = val;
      end else begin
        height_reg = val;
      end
      restart();
    endfunction

    function int unsigned dim(bit [CFG_W-1:0] v, int unsigned hi);
      if (v == 0) return 1;
      if (v > hi) return hi;
      return v;
    endfunction

    function int pending();
      return blurred_q.size();
    endfunction

    function void note_input(in_word_t w);
      int unsigned wd;
      int unsigned ht;
      int unsigned cnt;
      int unsigned sum [3];
      bit [PIX_W-1:0] px;
      bit [PIX_W-1:0] up;
      bit [PIX_W-1:0] mid;
      bit primed;
      bit last;
      out_word_t e;
      wd = dim(width_reg, LINE_DEPTH);
      ht = dim(height_reg, MAX_ROWS);
      px = (w.cmd == CMD_FLUSH) ? '0 : {w.red_in, w.green_in, w.blue_in};
      primed = (rows_in >= 2) || (rows_in == 1 && col_in >= 1);
      up = upper_row[col_in];
      mid = middle_row[col_in];
      upper_row[col_in] = mid;
      middle_row[col_in] = px;
      for (int r = 0; r < 3; r++) begin
        win[r][0] = win[r][1];
        win[r][1] = win[r][2];
      end
      win[0][2] = up;
      win[1][2] = mid;
      win[2][2] = px;
      col_in++;
      if (col_in >= wd) begin
        col_in = 0;
        if (rows_in < 2) rows_in++;
      end
      if (!primed) return;
      sum = '{0, 0, 0};
      cnt = 0;
      for (int r = 0; r < 3; r++) begin
        if (r == 0 && row_out == 0) continue;
        if (r == 2 && row_out + 1 >= ht) continue;
        for (int c = 0; c < 3; c++) begin
          if (c == 0 && col_out == 0) continue;
          if (c == 2 && col_out + 1 >= wd) continue;
          for (int ch = 0; ch < 3; ch++) sum[ch] += win[r][c][8*ch +: 8];
          cnt++;
        end
      end
      if (cnt == 0) cnt = 1;
      last = (row_out + 1 >= ht) && (col_out + 1 >= wd);
      e.red_out = CH_W'(sum[2] / cnt);
      e.green_out = CH_W'(sum[1] / cnt);
      e.blue_out = CH_W'(sum[0] / cnt);
      e.frame_end = last;
      blurred_q.push_back(e);
      if (last) begin
        restart();
      end else begin
        col_out++;
        if (col_out >= wd) begin
          col_out = 0;
          row_out++;
        end
      end
    endfunction

    function void check_result(out_word_t got);
      out_word_t e;
      if (blurred_q.size() == 0) begin
        $error("result word with no blurred pixel pending: %h", got);
        errors++;
        return;
      end
      e = blurred_q.pop_front();
      checked++;
      if (got.red_out !== e.red_out) begin
        $error("red_out: expected %0d, got %0d", e.red_out, got.red_out);
        errors++;
      end
      if (got.green_out !== e.green_out) begin
        $error("green_out: expected %0d, got %0d", e.green_out, got.green_out);
        errors++;
      end
      if (got.blue_out !== e.blue_out) begin
        $error("blue_out: expected %0d, got %0d", e.blue_out, got.blue_out);
        errors++;
      end
      if (got.frame_end !== e.frame_end) begin
        $error("frame_end: expected %0d, got %0d", e.frame_end, got.frame_end);
        errors++;
      end
    endfunction
  endclass

  localparam int LIMIT = 1000000;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES = 300;
  localparam int RANDOM_WORDS = 250;
  localparam int MIN_FRAMES = 6;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_word_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_word_t out_data;
  logic cfg_we = 1'b0;
  logic cfg_index = REG_FRAME_WIDTH;
  logic [CFG_W-1:0] cfg_data = '0;

  blur_scoreboard sb;
  bit offering = 1'b0;
  int idle_pct = 0;
  int stall_pct = 0;
  int hold_token = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int words_sent = 0;
  int settings = 0;
  int cycle_count = 0;
  int pace_idle [4] = '{0, 57, 0, 22};
  int pace_stall [4] = '{0, 0, 57, 22};

  box_blur_3x3_rgb_unit i_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT) begin
      $display("Timed out after %0d cycles", cycle_count);
      $display("== FAIL ==");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_result(out_data);
    if (hold_seen != hold_token) begin
      hold_seen = hold_token;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  function automatic logic [CH_W-1:0] rand_chan();
    case ($urandom_range(9))
      0: return 8'h00;
      1: return 8'hFF;
      default: return CH_W'($urandom_range(255));
    endcase
  endfunction

  function automatic in_word_t make_word(logic kind, logic [CH_W-1:0] r, logic [CH_W-1:0] g,
                                         logic [CH_W-1:0] b);
    in_word_t w;
    w.cmd = kind;
    w.red_in = r;
    w.green_in = g;
    w.blue_in = b;
    return w;
  endfunction

  task automatic set_pace(int idle, int stall);
    idle_pct = idle;
    stall_pct = stall;
  endtask

  task automatic idle_in();
    if (offering) begin
      in_valid <= 1'b0;
      offering = 1'b0;
    end
  endtask

  task automatic send_word(in_word_t w);
    while ($urandom_range(99) < idle_pct) begin
      idle_in();
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    offering = 1'b1;
    do @(posedge clk); while (!in_ready);
    sb.note_input(w);
    words_sent++;
  endtask

  task automatic wait_quiet();
    idle_in();
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [CFG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    sb.set_reg(idx, val);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_frame(logic [CFG_W-1:0] wr, logic [CFG_W-1:0] hr);
    wait_quiet();
    write_reg(REG_FRAME_WIDTH, wr);
    write_reg(REG_FRAME_HEIGHT, hr);
    settings++;
  endtask

  // cut > 0 stops the frame early after that many words
  task automatic run_frame(int wd, int ht, int cut, int pause_at, int hold_at);
    int total;
    int n;
    in_word_t w;
    total = wd * ht + wd + 1;
    n = (cut > 0) ? cut : total;
    for (int i = 0; i < n; i++) begin
      if (i == pause_at) wait_quiet();
      if (i == hold_at) hold_token++;
      w.red_in = rand_chan();
      w.green_in = rand_chan();
      w.blue_in = rand_chan();
      if (i < wd * ht) begin
        w.cmd = ($urandom_range(99) < 3) ? CMD_FLUSH : CMD_PIXEL;
      end else begin
        w.cmd = ($urandom_range(99) < 15) ? CMD_PIXEL : CMD_FLUSH;
      end
      send_word(w);
    end
  endtask

  initial begin
    int wd;
    int ht;
    int cur_w;
    int cur_h;
    logic [CFG_W-1:0] raw_w;
    int cut;
    int pause_at;
    int hold_at;
    int frame_no;
    int random_words;
    int start_count;
    bit need_cfg;
    sb = new();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset size: a few results off the top row of a 640 wide frame
    run_frame(640, 480, 645, -1, -1);

    set_frame(11'd3, 11'd3);
    send_word(make_word(CMD_PIXEL, 8'hFF, 8'hFF, 8'hFF));
    send_word(make_word(CMD_PIXEL, 8'h00, 8'h00, 8'h00));
    send_word(make_word(CMD_PIXEL, 8'hAA, 8'h55, 8'hFF));
    send_word(make_word(CMD_PIXEL, 8'h55, 8'hAA, 8'h00));
    send_word(make_word(CMD_PIXEL, 8'hFF, 8'hFF, 8'hFF));
    send_word(make_word(CMD_FLUSH, 8'hFF, 8'hFF, 8'hFF));
    send_word(make_word(CMD_PIXEL, 8'h01, 8'h80, 8'hFE));
    send_word(make_word(CMD_PIXEL, 8'hFF, 8'h00, 8'hFF));
    send_word(make_word(CMD_PIXEL, 8'h7F, 8'hFF, 8'h80));
    send_word(make_word(CMD_FLUSH, 8'hFF, 8'hFF, 8'hFF));
    send_word(make_word(CMD_PIXEL, 8'hFF, 8'hFF, 8'hFF));
    send_word(make_word(CMD_FLUSH, 8'h00, 8'h00, 8'h00));
    send_word(make_word(CMD_FLUSH, 8'hFF, 8'hFF, 8'hFF));

    set_frame(11'd0, 11'd0);
    send_word(make_word(CMD_PIXEL, 8'hFF, 8'h80, 8'h01));
    send_word(make_word(CMD_FLUSH, 8'hFF, 8'hFF, 8'hFF));
    send_word(make_word(CMD_FLUSH, 8'h00, 8'h00, 8'h00));

    set_frame(11'd1, 11'd3);
    send_word(make_word(CMD_PIXEL, 8'hFF, 8'hFF, 8'hFF));
    send_word(make_word(CMD_PIXEL, 8'h00, 8'hFF, 8'h00));
    send_word(make_word(CMD_PIXEL, 8'hFF, 8'h00, 8'hFF));
    send_word(make_word(CMD_FLUSH, 8'hFF, 8'hFF, 8'hFF));
    send_word(make_word(CMD_FLUSH, 8'hFF, 8'hFF, 8'hFF));

    set_frame(11'd2, 11'd1);
    send_word(make_word(CMD_PIXEL, 8'hFF, 8'h01, 8'hFE));
    send_word(make_word(CMD_PIXEL, 8'h00, 8'hFE, 8'h01));
    send_word(make_word(CMD_PIXEL, 8'hFF, 8'hFF, 8'hFF));
    send_word(make_word(CMD_FLUSH, 8'hFF, 8'hFF, 8'hFF));
    send_word(make_word(CMD_FLUSH, 8'h00, 8'h00, 8'h00));

    random_words = 0;
    frame_no = 0;
    need_cfg = 1'b1;
    cur_w = 2;
    cur_h = 1;
    while (random_words < RANDOM_WORDS || frame_no < MIN_FRAMES) begin
      set_pace(pace_idle[frame_no % 4], pace_stall[frame_no % 4]);
      pause_at = -1;
      hold_at = -1;
      cut = 0;
      if (frame_no == 4 || frame_no == 5) begin
        wd = 8;
        ht = 8;
        if (frame_no == 4) begin
          set_pace(0, 0);
          hold_at = 12;
        end else begin
          pause_at = 40;
        end
        set_frame(11'd8, 11'd8);
      end else if (need_cfg || $urandom_range(2) == 0) begin
        case ($urandom_range(9))
          0: begin
            wd = $urandom_range(9, 32);
            ht = $urandom_range(1, 4);
          end
          1: begin
            wd = $urandom_range(1, 4);
            ht = $urandom_range(9, 24);
          end
          default: begin
            wd = $urandom_range(1, 8);
            ht = $urandom_range(1, 8);
          end
        endcase
        raw_w = (wd == 1 && $urandom_range(1) == 1) ? 11'd0 : CFG_W'(wd);
        set_frame(raw_w, CFG_W'(ht));
        if ($urandom_range(9) == 0) cut = $urandom_range(1, wd * ht + wd);
      end else begin
        wd = cur_w;
        ht = cur_h;
      end
      cur_w = wd;
      cur_h = ht;
      start_count = words_sent;
      run_frame(wd, ht, cut, pause_at, hold_at);
      random_words += words_sent - start_count;
      need_cfg = (cut > 0);
      frame_no++;
    end

    set_pace(22, 22);
    set_frame(11'd0, 11'h7FF);
    run_frame(1, 1024, 0, -1, -1);

    set_pace(0, 0);
    idle_in();
    while (sb.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.pending() != 0) $error("%0d blurred pixels never arrived", sb.pending());
    $display("Sent %0d words across %0d frame sizes and checked %0d blurred pixels.",
             words_sent, settings, sb.checked);
    $display("Sizes ran from 1x1 to 640 wide and 1024 tall, with flushes and output stalls.");
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule

>>> box_blur_3x3_rgb_unit.f
rtl/bb3_pkg.sv
rtl/bb3_ram.sv
rtl/box_blur_3x3_rgb_unit.sv
tb/sv/tb.sv
